### rtl/rme_pkg.sv
// shared constants, register indexes and controller command type for the modexp core
package rme_pkg;

    // operand widths
    localparam int MOD_WIDTH      = 32;
    localparam int EXP_WIDTH      = 32;
    localparam int BLOCK_WIDTH    = 64;
    localparam int RESULT_WIDTH   = 32;
    localparam int PROD_WIDTH     = 2 * MOD_WIDTH;

    // configuration port
    localparam int CFG_IDX_WIDTH  = 2;
    localparam int CFG_DATA_WIDTH = (MOD_WIDTH > EXP_WIDTH) ? MOD_WIDTH : EXP_WIDTH;

    // register indexes
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_MODULUS  = CFG_IDX_WIDTH'(0);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_EXPONENT = CFG_IDX_WIDTH'(1);

    // reset values
    localparam logic [31:0] PUB_EXP_DEFAULT = (32'h1 << 16) | 32'h1;
    localparam logic [MOD_WIDTH-1:0] MODULUS_RESET = MOD_WIDTH'(2);
    localparam logic [EXP_WIDTH-1:0] EXPONENT_RESET = EXP_WIDTH'(PUB_EXP_DEFAULT);

    // controller counter widths
    localparam int RED_CNT_WIDTH  = $clog2(BLOCK_WIDTH);
    localparam int EXP_CNT_WIDTH  = $clog2(EXP_WIDTH);
    localparam logic [RED_CNT_WIDTH-1:0] RED_LAST = RED_CNT_WIDTH'(BLOCK_WIDTH - 1);
    localparam logic [EXP_CNT_WIDTH-1:0] EXP_LAST = EXP_CNT_WIDTH'(EXP_WIDTH - 1);

    // commands from controller to datapath
    typedef struct packed {
        logic load;      // capture block, modulus and exponent
        logic red_step;  // one bit of serial reduction on both lanes
        logic setup;     // base from reduced block, accumulator to one
        logic mul;       // both products into the reduction shifters
        logic update;    // commit base, and accumulator where the exponent bit is set; next exponent bit
        logic finish;    // accumulator goes to the output register
    } t_dp_cmd;

endpackage

### rtl/rme_block_if.sv
// request channel carrying one input block
interface rme_block_if;
    logic                          valid;
    logic                          ready;
    logic [rme_pkg::BLOCK_WIDTH-1:0] block;

    modport source (output valid, output block, input ready);
    modport sink   (input valid, input block, output ready);
endinterface

### rtl/rme_result_if.sv
// request channel carrying one exponentiation result
interface rme_result_if;
    logic                           valid;
    logic                           ready;
    logic [rme_pkg::RESULT_WIDTH-1:0] result;

    modport source (output valid, output result, input ready);
    modport sink   (input valid, input result, output ready);
endinterface

### rtl/rme_ctrl.sv
// sequencer for block reduction and square-and-multiply rounds
module rme_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    input  logic              i_out_busy,
    output logic              o_in_ready,
    output rme_pkg::t_dp_cmd  o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_RBLK  = 7'b0000010,
        S_SETUP = 7'b0000100,
        S_MUL   = 7'b0001000,
        S_RPRD  = 7'b0010000,
        S_UPD   = 7'b0100000,
        S_DONE  = 7'b1000000
    } t_state;

    t_state                                r_state, n_state;
    logic [rme_pkg::RED_CNT_WIDTH-1:0]     r_red_cnt, n_red_cnt;
    logic [rme_pkg::EXP_CNT_WIDTH-1:0]     r_exp_cnt, n_exp_cnt;

    // next state and commands
    always_comb begin
        n_state   = r_state;
        n_red_cnt = r_red_cnt;
        n_exp_cnt = r_exp_cnt;
        o_cmd     = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    n_red_cnt  = '0;
                    n_state    = S_RBLK;
                end
            end
            S_RBLK: begin
                o_cmd.red_step = 1'b1;
                n_red_cnt      = r_red_cnt + 1'b1;
                if (r_red_cnt == rme_pkg::RED_LAST) begin
                    n_state = S_SETUP;
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_exp_cnt   = '0;
                n_state     = S_MUL;
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_red_cnt = '0;
                n_state   = S_RPRD;
            end
            S_RPRD: begin
                o_cmd.red_step = 1'b1;
                n_red_cnt      = r_red_cnt + 1'b1;
                if (r_red_cnt == rme_pkg::RED_LAST) begin
                    n_state = S_UPD;
                end
            end
            S_UPD: begin
                o_cmd.update = 1'b1;
                n_exp_cnt    = r_exp_cnt + 1'b1;
                n_state      = (r_exp_cnt == rme_pkg::EXP_LAST) ? S_DONE : S_MUL;
            end
            S_DONE: begin
                if (!i_out_busy) begin
                    o_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // state and counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= S_IDLE;
            r_red_cnt <= '0;
            r_exp_cnt <= '0;
        end else begin
            r_state   <= n_state;
            r_red_cnt <= n_red_cnt;
            r_exp_cnt <= n_exp_cnt;
        end
    end

endmodule

### rtl/rme_datapath.sv
// modexp datapath: two multipliers and two bit-serial modular reducers
module rme_datapath (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  rme_pkg::t_dp_cmd                 i_cmd,
    input  logic [rme_pkg::BLOCK_WIDTH-1:0]  i_block,
    input  logic [rme_pkg::MOD_WIDTH-1:0]    i_modulus,
    input  logic [rme_pkg::EXP_WIDTH-1:0]    i_exponent,
    output logic [rme_pkg::MOD_WIDTH-1:0]    o_acc
);

    logic [rme_pkg::BLOCK_WIDTH-1:0] r_sh_a, r_sh_b;
    logic [rme_pkg::MOD_WIDTH-1:0]   r_rem_a, r_rem_b;
    logic [rme_pkg::MOD_WIDTH-1:0]   r_base, r_acc, r_n;
    logic [rme_pkg::EXP_WIDTH-1:0]   r_exp;
    logic [rme_pkg::PROD_WIDTH-1:0]  prod_a, prod_b;
    logic [rme_pkg::MOD_WIDTH-1:0]   step_a, step_b;

    // shift one bit into a remainder below n, subtract once if it reaches n
    function automatic logic [rme_pkg::MOD_WIDTH-1:0] red_bit(
        input logic [rme_pkg::MOD_WIDTH-1:0] rem,
        input logic                          din,
        input logic [rme_pkg::MOD_WIDTH-1:0] n
    );
        logic [rme_pkg::MOD_WIDTH:0] t;
        t = {rem, din};
        if (t >= {1'b0, n}) begin
            t = t - {1'b0, n};
        end
        return t[rme_pkg::MOD_WIDTH-1:0];
    endfunction

    // multiply-by-base and square products
    assign prod_a = rme_pkg::PROD_WIDTH'(r_acc) * rme_pkg::PROD_WIDTH'(r_base);
    assign prod_b = rme_pkg::PROD_WIDTH'(r_base) * rme_pkg::PROD_WIDTH'(r_base);

    assign step_a = red_bit(r_rem_a, r_sh_a[rme_pkg::BLOCK_WIDTH-1], r_n);
    assign step_b = red_bit(r_rem_b, r_sh_b[rme_pkg::BLOCK_WIDTH-1], r_n);

    // operand and lane registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem_a <= '0;
            r_rem_b <= '0;
            r_acc   <= rme_pkg::MOD_WIDTH'(1);
            r_base  <= '0;
            r_n     <= rme_pkg::MODULUS_RESET;
        end else begin
            // accumulator restarts so it stays below the newly captured modulus
            if (i_cmd.load) begin
                r_sh_a  <= i_block;
                r_sh_b  <= '0;
                r_rem_a <= '0;
                r_rem_b <= '0;
                r_acc   <= rme_pkg::MOD_WIDTH'(1);
                r_n     <= i_modulus;
                r_exp   <= i_exponent;
            end
            if (i_cmd.red_step) begin
                r_sh_a  <= r_sh_a << 1;
                r_sh_b  <= r_sh_b << 1;
                r_rem_a <= step_a;
                r_rem_b <= step_b;
            end
            if (i_cmd.setup) begin
                r_base <= r_rem_a;
                r_acc  <= rme_pkg::MOD_WIDTH'(1);
            end
            if (i_cmd.mul) begin
                r_sh_a  <= rme_pkg::BLOCK_WIDTH'(prod_a);
                r_sh_b  <= rme_pkg::BLOCK_WIDTH'(prod_b);
                r_rem_a <= '0;
                r_rem_b <= '0;
            end
            // take the product only where the exponent bit is set
            if (i_cmd.update) begin
                if (r_exp[0]) begin
                    r_acc <= r_rem_a;
                end
                r_base <= r_rem_b;
                r_exp  <= r_exp >> 1;
            end
        end
    end

    assign o_acc = r_acc;

    // residues stay below the captured modulus
    a_rem_a_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem_a < r_n) else $error("lane a remainder not below modulus");
    a_rem_b_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_rem_b < r_n) else $error("lane b remainder not below modulus");
    a_acc_below_n: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_acc < r_n) else $error("accumulator not below modulus");

endmodule

### rtl/rsa_modular_exponentiation_top.sv
// modular exponentiation core top level: config registers, result register, control and datapath
//
//  channel  dir  payload               handshake
//  i_blk    in   block   [63:0]        valid/ready
//  o_res    out  result  [31:0]        valid/ready
//  i_cfg_*  in   index 2b, data 32b    write enable, no wait
//
//  one block goes from accept to result valid through 64 reduction steps of the block,
//  a setup step, then 32 rounds of a multiply, 64 serial reduction steps and an update,
//  then the finish into the result register, which waits while a previous result is held
//  the serial reducers take most of the time; one block at a time, no new one until finish
//  a new block is taken while the previous result waits; its power holds until that leaves
//  reset is synchronous, active low; modulus returns to 2 and exponent to 0x10001
module rsa_modular_exponentiation_top (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_cfg_we,
    input  logic [rme_pkg::CFG_IDX_WIDTH-1:0]   i_cfg_idx,
    input  logic [rme_pkg::CFG_DATA_WIDTH-1:0]  i_cfg_data,
    rme_block_if.sink                           i_blk,
    rme_result_if.source                        o_res
);

    logic [rme_pkg::MOD_WIDTH-1:0]    r_modulus;
    logic [rme_pkg::EXP_WIDTH-1:0]    r_exponent;
    logic [rme_pkg::MOD_WIDTH-1:0]    cfg_mod;
    logic                             r_out_valid;
    logic [rme_pkg::RESULT_WIDTH-1:0] r_out_result;
    logic [rme_pkg::MOD_WIDTH-1:0]    acc;
    logic                             out_busy;
    rme_pkg::t_dp_cmd                 cmd;

    // config data cut to modulus width; the modulus register is never set below two
    assign cfg_mod = rme_pkg::MOD_WIDTH'(i_cfg_data);

    // configuration registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_modulus  <= rme_pkg::MODULUS_RESET;
            r_exponent <= rme_pkg::EXPONENT_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                rme_pkg::CFG_MODULUS: begin
                    r_modulus <= (cfg_mod < rme_pkg::MOD_WIDTH'(2)) ?
                                 rme_pkg::MOD_WIDTH'(2) : cfg_mod;
                end
                rme_pkg::CFG_EXPONENT: begin
                    r_exponent <= rme_pkg::EXP_WIDTH'(i_cfg_data);
                end
                default: begin
                end
            endcase
        end
    end

    assign out_busy = r_out_valid && !o_res.ready;

    rme_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_blk.valid),
        .i_out_busy (out_busy),
        .o_in_ready (i_blk.ready),
        .o_cmd      (cmd)
    );

    rme_datapath u_dp (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cmd      (cmd),
        .i_block    (i_blk.block),
        .i_modulus  (r_modulus),
        .i_exponent (r_exponent),
        .o_acc      (acc)
    );

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (cmd.finish) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (cmd.finish) begin
            r_out_result <= rme_pkg::RESULT_WIDTH'(acc);
        end
    end

    assign o_res.valid  = r_out_valid;
    assign o_res.result = r_out_result;

endmodule

### test/rsa_modular_exponentiation_checker.sv
// checker for the modexp core: mirrors the key registers, predicts each power and compares results
`timescale 1ns / 100ps

module rsa_modular_exponentiation_checker
    import rme_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_cfg_we,
    input  logic [CFG_IDX_WIDTH-1:0]  i_cfg_idx,
    input  logic [CFG_DATA_WIDTH-1:0] i_cfg_data,
    rme_block_if                      i_blk_mon,
    rme_result_if                     i_res_mon,
    output int                        o_pending,
    output int                        o_checked,
    output int                        o_fail_count
);

    // smallest modulus the core will hold
    localparam logic [MOD_WIDTH-1:0] MODULUS_FLOOR = MOD_WIDTH'(2);
    localparam int REPORT_LINES_MAX = 30;

    // one outstanding power with the operands that produced it
    typedef struct {
        logic [BLOCK_WIDTH-1:0]  block;
        logic [MOD_WIDTH-1:0]    modulus;
        logic [EXP_WIDTH-1:0]    exponent;
        logic [RESULT_WIDTH-1:0] power;
    } t_due_power;

    logic [MOD_WIDTH-1:0] key_modulus;
    logic [EXP_WIDTH-1:0] key_exponent;
    t_due_power           powers_due[$];
    int                   checked;
    int                   fails;

    // square-and-multiply over every exponent bit, lsb first
    function automatic logic [RESULT_WIDTH-1:0] rsa_power_mod(
        input logic [BLOCK_WIDTH-1:0] msg,
        input logic [MOD_WIDTH-1:0]   n,
        input logic [EXP_WIDTH-1:0]   e
    );
        logic [PROD_WIDTH-1:0] wide_n;
        logic [PROD_WIDTH-1:0] acc;
        logic [PROD_WIDTH-1:0] sq;
        wide_n = PROD_WIDTH'(n);
        acc    = PROD_WIDTH'(1) % wide_n;
        sq     = PROD_WIDTH'(msg % BLOCK_WIDTH'(n));
        for (int i = 0; i < EXP_WIDTH; i++) begin
            if (e[i])
                acc = (acc * sq) % wide_n;
            sq = (sq * sq) % wide_n;
        end
        return RESULT_WIDTH'(acc);
    endfunction

    task automatic report_mismatch(input string line);
        if (fails < REPORT_LINES_MAX)
            $display("[%0t] mismatch: %s", $time, line);
        fails++;
    endtask

    always @(posedge i_clk) begin : track
        t_due_power due;
        if (!i_rst_n) begin
            key_modulus  <= MODULUS_RESET;
            key_exponent <= EXPONENT_RESET;
            powers_due.delete();
            checked = 0;
            fails   = 0;
        end else begin
            // register writes, unmapped indexes are dropped
            if (i_cfg_we) begin
                case (i_cfg_idx)
                    CFG_MODULUS: begin
                        if (i_cfg_data[MOD_WIDTH-1:0] < MODULUS_FLOOR)
                            key_modulus <= MODULUS_FLOOR;
                        else
                            key_modulus <= i_cfg_data[MOD_WIDTH-1:0];
                    end
                    CFG_EXPONENT: key_exponent <= i_cfg_data[EXP_WIDTH-1:0];
                    default: ;
                endcase
            end

            // accepted block request: queue its power
            if (i_blk_mon.valid && i_blk_mon.ready) begin
                due.block    = i_blk_mon.block;
                due.modulus  = key_modulus;
                due.exponent = key_exponent;
                due.power    = rsa_power_mod(i_blk_mon.block, key_modulus, key_exponent);
                powers_due.push_back(due);
            end

            // accepted result request: compare with the oldest power
            if (i_res_mon.valid && i_res_mon.ready) begin
                if (powers_due.size() == 0) begin
                    report_mismatch($sformatf("result %h with no block outstanding",
                                              i_res_mon.result));
                end else begin
                    due = powers_due.pop_front();
                    checked++;
                    if (i_res_mon.result !== due.power)
                        report_mismatch($sformatf(
                            "block %h n %h e %h: result %h, want %h",
                            due.block, due.modulus, due.exponent,
                            i_res_mon.result, due.power));
                end
            end
        end
        o_pending    <= powers_due.size();
        o_checked    <= checked;
        o_fail_count <= fails;
    end

endmodule

### test/rsa_modular_exponentiation_top_tb.sv
// testbench top for the modexp core: clock, reset, key writes, block and result traffic, verdict
`timescale 1ns / 100ps

module rsa_modular_exponentiation_top_tb;
    import rme_pkg::*;

    // indexes with no register behind them
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED_LO = CFG_IDX_WIDTH'(2);
    localparam logic [CFG_IDX_WIDTH-1:0] CFG_UNMAPPED_HI = CFG_IDX_WIDTH'(3);

    localparam int RANDOM_PHASES  = 10;
    localparam int PHASE_BLOCKS   = 25;
    localparam int LONG_GAP_MAX   = 3000;
    localparam int TAIL_CYCLES    = 2200;
    localparam int WATCHDOG_LIMIT = 50000;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_WIDTH-1:0]  cfg_idx;
    logic [CFG_DATA_WIDTH-1:0] cfg_data;

    rme_block_if  blk_ch ();
    rme_result_if res_ch ();

    int  checker_pending;
    int  checker_checked;
    int  checker_fails;
    int  blocks_sent;
    int  key_settings;
    int  quiet_cycles = 0;
    bit  sender_eager;
    bit  receiver_eager;

    rsa_modular_exponentiation_top dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_cfg_we   (cfg_we),
        .i_cfg_idx  (cfg_idx),
        .i_cfg_data (cfg_data),
        .i_blk      (blk_ch),
        .o_res      (res_ch)
    );

    rsa_modular_exponentiation_checker u_checker (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_cfg_we     (cfg_we),
        .i_cfg_idx    (cfg_idx),
        .i_cfg_data   (cfg_data),
        .i_blk_mon    (blk_ch),
        .i_res_mon    (res_ch),
        .o_pending    (checker_pending),
        .o_checked    (checker_checked),
        .o_fail_count (checker_fails)
    );

    // 12 ns clock
    initial clk = 1'b0;
    always begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    // no gap when eager; else mostly none, some short, a few long, some of those longer than one exponentiation
    function automatic int pick_gap(input bit eager);
        int roll;
        roll = $urandom_range(0, 99);
        if (eager || roll < 60)
            return 0;
        if (roll < 88)
            return $urandom_range(1, 3);
        if (roll < 97)
            return $urandom_range(4, 30);
        return $urandom_range(200, LONG_GAP_MAX);
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_modulus();
        case ($urandom_range(0, 6))
            0: return $urandom_range(2, 255);
            1: return $urandom_range(0, 1);
            2: return '1;
            3: return $urandom | 32'h8000_0001;
            4: return $urandom_range(256, 65535);
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CFG_DATA_WIDTH-1:0] pick_exponent();
        case ($urandom_range(0, 6))
            0: return '0;
            1: return 1;
            2: return '1;
            3: return $urandom_range(2, 64);
            4: return PUB_EXP_DEFAULT;
            default: return $urandom;
        endcase
    endfunction

    // random blocks of several kinds; those around multiples of the modulus hit the reduction edges
    function automatic logic [BLOCK_WIDTH-1:0] pick_block(input logic [MOD_WIDTH-1:0] n);
        logic [BLOCK_WIDTH-1:0] multiple;
        case ($urandom_range(0, 9))
            5: return BLOCK_WIDTH'($urandom_range(n - 1, 0));
            6: begin
                multiple = BLOCK_WIDTH'($urandom) * BLOCK_WIDTH'(n);
                return multiple + BLOCK_WIDTH'($urandom_range(0, 2)) - BLOCK_WIDTH'(1);
            end
            7: return $urandom_range(0, 1) ? '1 : '0;
            8: return BLOCK_WIDTH'($urandom_range(0, 15));
            9: return {1'b1, 31'($urandom), 32'($urandom)};
            default: return {32'($urandom), 32'($urandom)};
        endcase
    endfunction

    // register write, enable stays up for back-to-back writes
    task automatic write_reg(input logic [CFG_IDX_WIDTH-1:0] idx,
                             input logic [CFG_DATA_WIDTH-1:0] data);
        cfg_we   <= 1'b1;
        cfg_idx  <= idx;
        cfg_data <= data;
        @(posedge clk);
    endtask

    task automatic end_writes();
        cfg_we <= 1'b0;
        key_settings++;
    endtask

    task automatic send_block(input logic [BLOCK_WIDTH-1:0] data);
        int gap;
        gap = pick_gap(sender_eager);
        if (gap > 0) begin
            blk_ch.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        blk_ch.valid <= 1'b1;
        blk_ch.block <= data;
        do @(posedge clk); while (!(blk_ch.valid && blk_ch.ready));
        blocks_sent++;
    endtask

    // sender holds off until every queued power has come back
    task automatic hold_until_drained();
        blk_ch.valid <= 1'b0;
        do @(posedge clk); while (checker_pending != 0);
    endtask

    // result side: random stalls before each result request
    initial begin : result_sink
        int stall;
        forever begin
            stall = pick_gap(receiver_eager);
            if (stall > 0) begin
                res_ch.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            res_ch.ready <= 1'b1;
            do @(posedge clk); while (!(res_ch.valid && res_ch.ready));
        end
    end

    // watchdog on cycles where no request moves
    always @(posedge clk) begin
        if ((blk_ch.valid && blk_ch.ready) || (res_ch.valid && res_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no request moved for %0d cycles", quiet_cycles);
            $display("SCOREBOARD MISMATCH");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin : stimulus
        logic [CFG_DATA_WIDTH-1:0] n_raw;
        logic [MOD_WIDTH-1:0]      n_held;
        blocks_sent    = 0;
        key_settings   = 0;
        sender_eager   = 1'b0;
        receiver_eager = 1'b0;
        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_idx      <= CFG_MODULUS;
        cfg_data     <= '0;
        blk_ch.valid <= 1'b0;
        blk_ch.block <= '0;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;

        // reset keys: modulus two, public exponent
        send_block('0);
        send_block(64'd1);
        send_block('1);
        send_block(64'h8000_0000_0000_0000);
        hold_until_drained();

        // modulus zero and one floor to two, zero exponent, unmapped writes dropped
        write_reg(CFG_MODULUS, '0);
        write_reg(CFG_EXPONENT, '0);
        write_reg(CFG_UNMAPPED_LO, '1);
        write_reg(CFG_UNMAPPED_HI, 32'h0000_0005);
        end_writes();
        send_block(64'd7);
        send_block('0);
        hold_until_drained();
        write_reg(CFG_MODULUS, 32'd1);
        end_writes();
        send_block(64'h5555_5555_5555_5555);
        hold_until_drained();

        // widest modulus and exponent, zero base
        write_reg(CFG_MODULUS, '1);
        write_reg(CFG_EXPONENT, '1);
        end_writes();
        send_block('0);
        send_block('1);
        send_block(64'h0000_0000_FFFF_FFFF);
        send_block(64'h0000_0000_FFFF_FFFE);
        send_block(64'h0000_0001_0000_0000);
        send_block(64'hAAAA_AAAA_5555_5555);
        hold_until_drained();

        // small textbook key: encrypt then decrypt
        write_reg(CFG_MODULUS, 32'd3233);
        write_reg(CFG_EXPONENT, 32'd17);
        end_writes();
        send_block(64'd65);
        send_block(64'd3233 * 64'd1000 + 64'd65);
        hold_until_drained();
        write_reg(CFG_EXPONENT, 32'd2753);
        write_reg(CFG_UNMAPPED_HI, $urandom);
        end_writes();
        send_block(64'd2790);
        send_block(64'd3233);
        hold_until_drained();

        // largest 32-bit prime, exponents one and two
        write_reg(CFG_MODULUS, 32'hFFFF_FFFB);
        write_reg(CFG_EXPONENT, 32'd1);
        end_writes();
        send_block(64'h0123_4567_89AB_CDEF);
        hold_until_drained();
        write_reg(CFG_EXPONENT, 32'd2);
        end_writes();
        send_block(64'h0123_4567_89AB_CDEF);
        hold_until_drained();

        // random keys, random blocks, random idling per phase
        for (int ph = 0; ph < RANDOM_PHASES; ph++) begin
            n_raw  = pick_modulus();
            n_held = (n_raw[MOD_WIDTH-1:0] < 2) ? MOD_WIDTH'(2) : n_raw[MOD_WIDTH-1:0];
            write_reg(CFG_MODULUS, n_raw);
            write_reg(CFG_EXPONENT, pick_exponent());
            if ($urandom_range(0, 3) == 0)
                write_reg($urandom_range(0, 1) ? CFG_UNMAPPED_LO : CFG_UNMAPPED_HI, $urandom);
            end_writes();
            sender_eager   = ($urandom_range(0, 3) == 0);
            receiver_eager = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < PHASE_BLOCKS; k++) begin
                send_block(pick_block(n_held));
                if (ph == 2 && k == PHASE_BLOCKS / 2)
                    hold_until_drained();
            end
            hold_until_drained();
        end

        // let any stray result surface
        repeat (TAIL_CYCLES) @(posedge clk);

        $display("covered %0d blocks under %0d key settings, %0d results compared",
                 blocks_sent, key_settings, checker_checked);
        $display("incl. modulus floor, zero exponent, zero base, unmapped writes, operand extremes");
        if (checker_fails == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
